### hdl/rssi_ema_pkg.sv
// ----------------------------------------------------------------------------
// rssi_ema_pkg
// Shared types and constants for the per-channel rssi smoother.
// ----------------------------------------------------------------------------
package rssi_ema_pkg;

  typedef enum logic [1:0] {
    FUNC_SAMPLE     = 2'd0,
    FUNC_CONNECT    = 2'd1,
    FUNC_DISCONNECT = 2'd2,
    FUNC_CLEAR_ALL  = 2'd3
  } func_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SUM  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_EMA1 = 6'b001000,
    ST_EMA2 = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  localparam int RING_LEN = 3;

  // floor(x/3) = (x*683) >> 11 and floor(x/10) = (x*205) >> 11 for x < 1024
  localparam int          RECIP_SHIFT = 11;
  localparam logic [10:0] DIV3_RECIP  = 11'd683;
  localparam logic [10:0] DIV10_RECIP = 11'd205;

  localparam logic signed [7:0] EMA_RESTART = -8'sd70;
  localparam logic signed [8:0] DBM_MAX     = 9'sd127;
  localparam logic signed [8:0] DBM_MIN     = -9'sd127;
  localparam logic [7:0]        CODE_OFFSET = 8'd128;

endpackage

### hdl/rssi_avg_ema_filter_unit.sv
// ----------------------------------------------------------------------------
// rssi_avg_ema_filter_unit
// Per-channel rssi smoother: 3-point moving average followed by an ema.
// ----------------------------------------------------------------------------
// One item at a time. A sample transfer runs SUM over its n ring entries, then
// DIV, EMA1, EMA2 and FIN, where n (1 to 3) is the channel's filled ring entries:
// the ring is summed one entry per cycle through a shared adder, then one
// shared multiplier serves the divide by three and the ema step.
// Connect, disconnect and clear-all transfers go straight to FIN. The result sits
// in an output register, so a new transfer is taken while it waits.
module rssi_avg_ema_filter_unit #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // channel[1:0], raw_dbm[9:2], zero pad
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // filtered_dbm[7:0], report_code[15:8],
                                      // report_channel[17:16], zero pad
  output logic        m_axis_tuser    // report_valid
);
  import rssi_ema_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state;

  logic signed [7:0] ring [CHANNELS][RING_LEN];
  logic [1:0]        fill_count [CHANNELS];
  logic [1:0]        write_slot [CHANNELS];
  logic signed [7:0] ema_value [CHANNELS];
  logic              ema_started [CHANNELS];
  logic              channel_active [CHANNELS];

  logic [1:0]        ch_q;
  logic [1:0]        n_q;
  logic [1:0]        cnt;
  logic signed [9:0] sum;
  logic signed [7:0] avg;
  logic [9:0]        pmag;
  logic              psign;
  logic signed [7:0] res_dbm;
  logic              res_valid;

  logic signed [7:0] out_dbm;
  logic [1:0]        out_ch;
  logic              out_flag;

  // input fields
  func_t             func_in;
  logic [1:0]        ch_in;
  logic signed [7:0] raw_in;
  logic [CH_W-1:0]   idx_in;
  logic [CH_W-1:0]   idx_q;
  logic              in_range;
  logic [1:0]        slot_in;
  logic [1:0]        n_in;

  // shared multiplier and datapath
  logic [9:0]        mul_a;
  logic [10:0]       mul_k;
  logic [20:0]       mul_p;
  logic [9:0]        mul_q;
  logic [9:0]        sum_mag;
  logic [9:0]        div_q;
  logic signed [8:0] diff;
  logic [8:0]        dmag;
  logic signed [8:0] step;
  logic signed [8:0] e_raw;
  logic signed [8:0] e_clamp;

  assign func_in  = func_t'(s_axis_tuser);
  assign ch_in    = s_axis_tdata[1:0];
  assign raw_in   = s_axis_tdata[9:2];
  assign idx_in   = CH_W'(ch_in);
  assign idx_q    = CH_W'(ch_q);
  assign in_range = (32'(ch_in) < CHANNELS);
  assign slot_in  = (write_slot[idx_in] >= 2'(RING_LEN)) ? 2'd0 : write_slot[idx_in];
  assign n_in     = (fill_count[idx_in] < 2'(RING_LEN)) ? fill_count[idx_in] + 2'd1
                                                        : 2'(RING_LEN);

  assign sum_mag = sum[9] ? 10'(-sum) : 10'(sum);
  assign mul_a   = (state == ST_DIV) ? sum_mag : pmag;
  assign mul_k   = (state == ST_DIV) ? DIV3_RECIP : DIV10_RECIP;
  assign mul_p   = 21'(mul_a) * 21'(mul_k);
  assign mul_q   = mul_p[20:RECIP_SHIFT];

  always_comb begin
    case (n_q)
      2'd1:    div_q = sum_mag;
      2'd2:    div_q = sum_mag >> 1;
      default: div_q = mul_q;
    endcase
  end

  assign diff  = 9'(avg) - 9'(ema_value[idx_q]);
  assign dmag  = diff[8] ? 9'(-diff) : 9'(diff);
  assign step  = psign ? -9'(signed'(mul_q[8:0])) : 9'(signed'(mul_q[8:0]));
  assign e_raw = ema_started[idx_q] ? 9'(ema_value[idx_q]) + step : 9'(avg);

  always_comb begin
    if (e_raw > DBM_MAX) begin
      e_clamp = DBM_MAX;
    end else if (e_raw < DBM_MIN) begin
      e_clamp = DBM_MIN;
    end else begin
      e_clamp = e_raw;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int r = 0; r < RING_LEN; r++) begin
          ring[c][r] <= '0;
        end
        fill_count[c]     <= '0;
        write_slot[c]     <= '0;
        ema_value[c]      <= '0;
        ema_started[c]    <= 1'b0;
        channel_active[c] <= 1'b0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ch_q    <= ch_in;
            res_dbm <= '0;
            if (func_in == FUNC_CLEAR_ALL) begin
              res_valid <= 1'b0;
              state     <= ST_FIN;
              for (int c = 0; c < CHANNELS; c++) begin
                fill_count[c]  <= '0;
                write_slot[c]  <= '0;
                ema_started[c] <= 1'b0;
                ema_value[c]   <= EMA_RESTART;
              end
            end else if (in_range) begin
              case (func_in)
                FUNC_SAMPLE: begin
                  ring[idx_in][slot_in] <= raw_in;
                  write_slot[idx_in]    <= (slot_in == 2'(RING_LEN - 1)) ? 2'd0
                                                                          : slot_in + 2'd1;
                  fill_count[idx_in]    <= n_in;
                  n_q       <= n_in;
                  cnt       <= '0;
                  sum       <= '0;
                  res_valid <= channel_active[idx_in];
                  state     <= ST_SUM;
                end
                FUNC_CONNECT: begin
                  res_valid              <= 1'b0;
                  state                  <= ST_FIN;
                  channel_active[idx_in] <= 1'b1;
                  fill_count[idx_in]     <= '0;
                  write_slot[idx_in]     <= '0;
                  ema_started[idx_in]    <= 1'b0;
                  ema_value[idx_in]      <= EMA_RESTART;
                end
                default: begin
                  res_valid <= 1'b0;
                  state     <= ST_FIN;
                  for (int r = 0; r < RING_LEN; r++) begin
                    ring[idx_in][r] <= '0;
                  end
                  channel_active[idx_in] <= 1'b0;
                  fill_count[idx_in]     <= '0;
                  write_slot[idx_in]     <= '0;
                  ema_started[idx_in]    <= 1'b0;
                  ema_value[idx_in]      <= '0;
                end
              endcase
            end else begin
              res_valid <= 1'b0;
              state     <= ST_FIN;
            end
          end
        end
        ST_SUM: begin
          sum <= sum + 10'(ring[idx_q][cnt]);
          cnt <= cnt + 2'd1;
          if (cnt == n_q - 2'd1) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          avg   <= sum[9] ? 8'(-div_q) : 8'(div_q);
          state <= ST_EMA1;
        end
        ST_EMA1: begin
          pmag  <= {dmag, 1'b0} + 10'(dmag);
          psign <= diff[8];
          state <= ST_EMA2;
        end
        ST_EMA2: begin
          ema_value[idx_q]   <= 8'(e_clamp);
          ema_started[idx_q] <= 1'b1;
          res_dbm            <= 8'(e_clamp);
          state              <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_dbm       <= res_dbm;
            out_ch        <= ch_q;
            out_flag      <= res_valid;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, out_ch, 8'(out_dbm) + CODE_OFFSET, out_dbm};
  assign m_axis_tuser = out_flag;

  a_code_matches: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:8] == (m_axis_tdata[7:0] + CODE_OFFSET)))
    else $error("report code does not match filtered value");

  a_no_min_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80))
    else $error("filtered value escaped clamp");

  a_sum_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) |-> (cnt < n_q))
    else $error("ring sum ran past fill count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again before item finished");

endmodule

### tb/rssi_avg_ema_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_avg_ema_filter_unit_tb
// Drives func/channel/raw dBm transfers into the rssi smoother under random
// idling on both streams, long output back-pressure and a full drain pause.
// A directed table covers reset, extremes, connect, disconnect and clear-all.
// A long random run follows, mostly samples on connected links. Every report
// is compared field by field with a per-link ring/average/ema model kept here.
// ----------------------------------------------------------------------------
module rssi_avg_ema_filter_unit_tb;
  import rssi_ema_pkg::*;

  localparam int NUM_LINKS    = 4;
  localparam int RAND_ITEMS   = 1625;
  localparam int HOLD_AT      = 450;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 1000;
  localparam int EMA_GAIN_NUM = 3;
  localparam int EMA_GAIN_DEN = 10;
  localparam int RESTART_DBM  = -70;
  localparam int CLAMP_DBM    = 127;

  typedef struct packed {
    logic signed [7:0] filtered;
    logic [7:0]        code;
    logic              valid;
    logic [1:0]        channel;
  } rssi_report_t;

  typedef struct packed {
    func_t             func;
    logic [1:0]        ch;
    logic [7:0]        raw;
    logic              typed;
    logic [7:0]        filt;
    logic [7:0]        code;
    logic              valid;
  } stim_row_t;

  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{FUNC_SAMPLE,     2'd0, 8'd0,   1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_CONNECT,    2'd0, 8'd0,   1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'h80,  1'b1, 8'h81,  8'd1,   1'b1},
    '{FUNC_SAMPLE,     2'd0, 8'h7f,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'h7f,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'h7f,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'hff,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_CONNECT,    2'd1, 8'h7f,  1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_SAMPLE,     2'd1, 8'h7f,  1'b1, 8'h7f,  8'd255, 1'b1},
    '{FUNC_SAMPLE,     2'd1, 8'h80,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd1, 8'h80,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd2, 8'hce,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_CLEAR_ALL,  2'd3, 8'h80,  1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'h05,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'hf9,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_SAMPLE,     2'd2, 8'ha6,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_DISCONNECT, 2'd0, 8'hff,  1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_SAMPLE,     2'd0, 8'h80,  1'b1, 8'h81,  8'd1,   1'b0},
    '{FUNC_CONNECT,    2'd3, 8'h00,  1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_SAMPLE,     2'd3, 8'hff,  1'b1, 8'hff,  8'd127, 1'b1},
    '{FUNC_SAMPLE,     2'd3, 8'hff,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_DISCONNECT, 2'd2, 8'h00,  1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_CLEAR_ALL,  2'd0, 8'h55,  1'b1, 8'd0,   8'd128, 1'b0},
    '{FUNC_SAMPLE,     2'd1, 8'hc4,  1'b0, 8'd0,   8'd0,   1'b0},
    '{FUNC_CONNECT,    2'd2, 8'haa,  1'b1, 8'd0,   8'd128, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // channel[1:0], raw_dbm[9:2], zero pad
  logic [1:0]  s_axis_tuser = '0;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // filtered_dbm[7:0], report_code[15:8],
                                    // report_channel[17:16], zero pad
  logic        m_axis_tuser;        // report_valid

  rssi_avg_ema_filter_unit #(.CHANNELS(NUM_LINKS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // per-link smoother state
  logic signed [7:0] link_ring [NUM_LINKS][RING_LEN];
  logic [1:0]        link_fill [NUM_LINKS];
  logic [1:0]        link_slot [NUM_LINKS];
  logic signed [7:0] link_ema [NUM_LINKS];
  logic              link_started [NUM_LINKS];
  logic              link_active [NUM_LINKS];

  rssi_report_t pending_reports [$];
  int  errors;
  int  reports_seen;
  int  n_samples, n_reported, n_connects, n_disconnects, n_clears;
  bit  no_idle;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void restart_link(input int ch);
    link_fill[ch]    = '0;
    link_slot[ch]    = '0;
    link_started[ch] = 1'b0;
    link_ema[ch]     = 8'(RESTART_DBM);
  endfunction

  function automatic rssi_report_t predict_rssi(input func_t f, input logic [1:0] ch,
                                                input logic signed [7:0] raw);
    rssi_report_t r;
    int k, s, sum, avg, e;
    r = '{filtered: '0, code: 8'd128, valid: 1'b0, channel: ch};
    if (f == FUNC_CLEAR_ALL) begin
      for (k = 0; k < NUM_LINKS; k++) restart_link(k);
    end else if (int'(ch) < NUM_LINKS) begin
      case (f)
        FUNC_CONNECT: begin
          link_active[ch] = 1'b1;
          restart_link(ch);
        end
        FUNC_DISCONNECT: begin
          for (k = 0; k < RING_LEN; k++) link_ring[ch][k] = '0;
          link_fill[ch]    = '0;
          link_slot[ch]    = '0;
          link_ema[ch]     = '0;
          link_started[ch] = 1'b0;
          link_active[ch]  = 1'b0;
        end
        default: begin
          s = (int'(link_slot[ch]) >= RING_LEN) ? 0 : int'(link_slot[ch]);
          link_ring[ch][s] = raw;
          link_slot[ch] = 2'((s + 1) % RING_LEN);
          if (int'(link_fill[ch]) < RING_LEN) link_fill[ch] = link_fill[ch] + 2'd1;
          sum = 0;
          for (k = 0; k < int'(link_fill[ch]); k++) sum += int'(link_ring[ch][k]);
          avg = sum / int'(link_fill[ch]);
          if (!link_started[ch]) begin
            e = avg;
            link_started[ch] = 1'b1;
          end else begin
            e = int'(link_ema[ch]);
            e = e + ((avg - e) * EMA_GAIN_NUM) / EMA_GAIN_DEN;
          end
          if (e > CLAMP_DBM) e = CLAMP_DBM;
          else if (e < -CLAMP_DBM) e = -CLAMP_DBM;
          link_ema[ch] = 8'(e);
          r.filtered = 8'(e);
          r.code     = 8'(e + 128);
          r.valid    = link_active[ch];
        end
      endcase
    end
    return r;
  endfunction

  function automatic int draw_idle();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_transfer(input func_t f, input logic [1:0] ch, input logic [7:0] raw,
                               input logic typed, input logic [7:0] t_filt,
                               input logic [7:0] t_code, input logic t_valid,
                               input int gap, input bit drain);
    rssi_report_t want;
    if (drain) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (pending_reports.size() != 0);
    end else if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
    end
    repeat (gap) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, raw, ch};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    want = predict_rssi(f, ch, raw);
    if (typed) begin
      want.filtered = t_filt;
      want.code     = t_code;
      want.valid    = t_valid;
    end
    pending_reports.push_back(want);
    case (f)
      FUNC_SAMPLE: begin
        n_samples++;
        if (want.valid) n_reported++;
      end
      FUNC_CONNECT:    n_connects++;
      FUNC_DISCONNECT: n_disconnects++;
      default:         n_clears++;
    endcase
  endtask

  // receive side: random stalls plus one long hold-off
  initial begin
    int stall;
    rssi_report_t got, want;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_idle();
      if (reports_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = '{filtered: m_axis_tdata[7:0], code: m_axis_tdata[15:8],
              valid: m_axis_tuser, channel: m_axis_tdata[17:16]};
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected report: filt %0d code %0d valid %0b ch %0d",
                   $realtime, got.filtered, got.code, got.valid, got.channel);
      end else begin
        want = pending_reports.pop_front();
        if (got.filtered !== want.filtered || got.code !== want.code ||
            got.valid !== want.valid || got.channel !== want.channel) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] report %0d mismatch: filt %0d/%0d code %0d/%0d valid %0b/%0b ch %0d/%0d (exp/act)",
                     $realtime, reports_seen, want.filtered, got.filtered, want.code, got.code,
                     want.valid, got.valid, want.channel, got.channel);
        end
      end
    end
  end

  initial begin
    int i, pick;
    func_t f;
    logic [1:0] ch;
    logic [7:0] raw;
    for (i = 0; i < NUM_LINKS; i++) begin
      for (pick = 0; pick < RING_LEN; pick++) link_ring[i][pick] = '0;
      link_fill[i]    = '0;
      link_slot[i]    = '0;
      link_ema[i]     = '0;
      link_started[i] = 1'b0;
      link_active[i]  = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_transfer(DIR_TAB[i].func, DIR_TAB[i].ch, DIR_TAB[i].raw, DIR_TAB[i].typed,
                    DIR_TAB[i].filt, DIR_TAB[i].code, DIR_TAB[i].valid, draw_idle(), 1'b0);

    // mostly samples on a few live links, with occasional link churn
    for (i = 0; i < RAND_ITEMS; i++) begin
      no_idle = (i >= 400 && i < 700);
      pick = $urandom_range(0, 99);
      if (pick < 84)      f = FUNC_SAMPLE;
      else if (pick < 92) f = FUNC_CONNECT;
      else if (pick < 97) f = FUNC_DISCONNECT;
      else                f = FUNC_CLEAR_ALL;
      ch = 2'($urandom_range(0, NUM_LINKS - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)      raw = 8'h80;
      else if (pick == 1) raw = 8'h7f;
      else if (pick < 6)  raw = 8'($urandom_range(0, 60) - 100);
      else                raw = 8'($urandom());
      send_transfer(f, ch, raw, 1'b0, '0, '0, 1'b0, draw_idle(), i == DRAIN_AT);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d samples (%0d reported on live links), %0d connects,",
             n_samples, n_reported, n_connects);
    $display("%0d disconnects, %0d clear-alls, %0d reports checked, %0d errors",
             n_disconnects, n_clears, reports_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
